// ===== src/hpt_pkg.sv =====
// Package for the homogeneous point transform: fixed-point widths, types
// and saturation limits shared by the pipeline stages. No dependencies.
package hpt_pkg;

  localparam int COEF_WIDTH = 16;   // signed coefficient, 12 fraction bits
  localparam int DATA_WIDTH = 24;   // signed vector component, 12 fraction bits
  localparam int FRAC_BITS  = 12;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_COLS   = 4;
  localparam int NUM_TERMS  = NUM_ROWS * NUM_COLS;
  localparam int SLOT_WIDTH = 16;   // coefficient slot in a row register
  localparam int ROW_WIDTH  = SLOT_WIDTH * NUM_COLS;
  localparam int CFG_IDX_W  = 3;    // one spare bit so stray indexes can be dropped

  localparam int PROD_W = COEF_WIDTH + DATA_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam int TDATA_W = ((NUM_COLS * DATA_WIDTH + 7) / 8) * 8;

  localparam logic [ROW_WIDTH-1:0] ONE_FIXED = ROW_WIDTH'(1) << FRAC_BITS;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] DATA_MAX =
    {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DATA_MIN =
    {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PAIR_W-1:0]     pair_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [ROW_WIDTH-1:0]         row_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

endpackage

// ===== src/homogeneous_point_transform.sv =====
// Homogeneous point transform: 4x4 matrix times 4-vector, fixed point.
// Top level; depends on hpt_pkg, hpt_mult, hpt_add and hpt_round.
//
// Usage:
//   Input stream  s_*: one beat per vector, tdata = {w, z, y, x}, each
//                 24-bit signed Q11.12, x in the lowest bits.
//   Output stream m_*: one beat per vector, tdata = {w, z, y, x} rounded
//                 and saturated Q11.12; tuser = saturated flag, set when any
//                 component was clamped.
//   Config port   cfg_*: cfg_index 0..3 writes matrix row 0..3 (four signed
//                 Q3.12 coefficients, column j in bits 16j+15..16j). Any
//                 other index is dropped. cfg_ready is always high; write
//                 rows only while no vector is in flight.
// Pipeline: four registered stages from an input beat to its output beat
//   (products, pair sums, row sums, round/saturate register).
// Throughput: one vector per cycle while m_tready stays high; every stage is a register
//   with its own valid bit, and the sixteen multipliers sit in one stage.
// Reset: rst (synchronous) empties the pipeline and loads the identity.
// Stall: when m_tready is low, the output beat holds; upstream stages
//   keep filling bubbles and stop only when full, so s_tready falls once
//   all four stages hold a beat. Nothing is dropped or repeated.
module homogeneous_point_transform (
  input  logic                          clk,
  input  logic                          rst,
  // input vectors; tdata: vec_x, vec_y, vec_z, vec_w (low to high)
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hpt_pkg::TDATA_W-1:0]   s_tdata,
  // results; tdata: out_x, out_y, out_z, out_w (low to high)
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hpt_pkg::TDATA_W-1:0]   m_tdata,
  // tuser: saturated
  output logic                          m_tuser,
  // matrix row writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  hpt_pkg::cfg_idx_t             cfg_index,
  input  hpt_pkg::row_t                 cfg_data
);
  import hpt_pkg::*;

  row_t  matrix_row [NUM_ROWS];
  coef_t coef [NUM_TERMS];
  data_t vec  [NUM_COLS];
  prod_t prod [NUM_TERMS];
  sum_t  sum  [NUM_ROWS];
  data_t comp [NUM_ROWS];

  logic mult_valid, pair_valid, sum_valid;
  logic en_mult, en_pair, en_sum, en_out;

  // ---- matrix registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        matrix_row[r] <= ONE_FIXED << (SLOT_WIDTH * r);
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_ROWS))) begin
      matrix_row[cfg_index[1:0]] <= cfg_data;
    end
  end

  // low COEF_WIDTH bits of each slot are the coefficient
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      coef[k] = matrix_row[k / NUM_COLS][SLOT_WIDTH*(k % NUM_COLS) +: COEF_WIDTH];
    end
    for (int j = 0; j < NUM_COLS; j++) begin
      vec[j] = s_tdata[DATA_WIDTH*j +: DATA_WIDTH];
    end
  end

  // ---- stall control: a stage moves when it is empty or the next moves ----
  assign en_out   = !m_tvalid   || m_tready;
  assign en_sum   = !sum_valid  || en_out;
  assign en_pair  = !pair_valid || en_sum;
  assign en_mult  = !mult_valid || en_pair;
  assign s_tready = en_mult;

  hpt_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .en        (en_mult),
    .in_valid  (s_tvalid),
    .vec       (vec),
    .coef      (coef),
    .out_valid (mult_valid),
    .prod      (prod)
  );

  hpt_add u_add (
    .clk        (clk),
    .rst        (rst),
    .en_pair    (en_pair),
    .en_sum     (en_sum),
    .in_valid   (mult_valid),
    .prod       (prod),
    .pair_valid (pair_valid),
    .sum_valid  (sum_valid),
    .sum        (sum)
  );

  hpt_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en_out),
    .in_valid  (sum_valid),
    .sum       (sum),
    .out_valid (m_tvalid),
    .comp      (comp),
    .sat       (m_tuser)
  );

  // ---- output packing, pad bits zero ----
  always_comb begin
    m_tdata = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      m_tdata[DATA_WIDTH*r +: DATA_WIDTH] = comp[r];
    end
  end

endmodule

// ===== src/hpt_mult.sv =====
// Stage 1 of the transform: sixteen coefficient-by-component products.
// Depends on hpt_pkg.
module hpt_mult (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  hpt_pkg::data_t  vec  [hpt_pkg::NUM_COLS],
  input  hpt_pkg::coef_t  coef [hpt_pkg::NUM_TERMS],
  output logic            out_valid,
  output hpt_pkg::prod_t  prod [hpt_pkg::NUM_TERMS]
);
  import hpt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // term k is row k/4, column k%4
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        prod[k] <= coef[k] * vec[k % NUM_COLS];
      end
    end
  end

endmodule

// ===== src/hpt_add.sv =====
// Stages 2 and 3 of the transform: pair sums, then the full row sums.
// Depends on hpt_pkg.
module hpt_add (
  input  logic            clk,
  input  logic            rst,
  input  logic            en_pair,
  input  logic            en_sum,
  input  logic            in_valid,
  input  hpt_pkg::prod_t  prod [hpt_pkg::NUM_TERMS],
  output logic            pair_valid,
  output logic            sum_valid,
  output hpt_pkg::sum_t   sum  [hpt_pkg::NUM_ROWS]
);
  import hpt_pkg::*;

  pair_t pair [2*NUM_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (en_pair) pair_valid <= in_valid;
      if (en_sum)  sum_valid  <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_pair) begin
      for (int p = 0; p < 2*NUM_ROWS; p++) begin
        pair[p] <= PAIR_W'(prod[2*p]) + PAIR_W'(prod[2*p+1]);
      end
    end
    if (en_sum) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum[r] <= SUM_W'(pair[2*r]) + SUM_W'(pair[2*r+1]);
      end
    end
  end

endmodule

// ===== src/hpt_round.sv =====
// Stage 4 of the transform: round half up, drop fraction bits, saturate,
// and hold the result beat for the output channel. Depends on hpt_pkg.
module hpt_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  hpt_pkg::sum_t   sum  [hpt_pkg::NUM_ROWS],
  output logic            out_valid,
  output hpt_pkg::data_t  comp [hpt_pkg::NUM_ROWS],
  output logic            sat
);
  import hpt_pkg::*;

  sum_t  shifted  [NUM_ROWS];
  data_t comp_next [NUM_ROWS];
  logic  [NUM_ROWS-1:0] clamp;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      // arithmetic shift floors, so adding half first rounds toward +inf
      shifted[r] = (sum[r] + HALF_LSB) >>> FRAC_BITS;
      clamp[r]   = 1'b1;
      if (shifted[r] > DATA_MAX) begin
        comp_next[r] = DATA_MAX[DATA_WIDTH-1:0];
      end else if (shifted[r] < DATA_MIN) begin
        comp_next[r] = DATA_MIN[DATA_WIDTH-1:0];
      end else begin
        comp_next[r] = shifted[r][DATA_WIDTH-1:0];
        clamp[r]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp <= comp_next;
      sat  <= |clamp;
    end
  end

endmodule
